>>> design/gpio_port_with_pin_interrupts_assert.svh
// Assertion macros shared by the GPIO port.
// Each macro checks one implication on the rising clock edge, with reset
// switching the check off.
`ifndef GPIO_PORT_WITH_PIN_INTERRUPTS_ASSERT_SVH
`define GPIO_PORT_WITH_PIN_INTERRUPTS_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GPIO_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GPIO_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/gpio_pkg.sv
package gpio_pkg;

   // Operation codes carried in the func field.
   localparam logic [1:0] FUNC_READ  = 2'd0;
   localparam logic [1:0] FUNC_WRITE = 2'd1;
   localparam logic [1:0] FUNC_TICK  = 2'd2;

   // Register numbering.
   localparam logic [2:0] REG_DATA   = 3'd0;
   localparam logic [2:0] REG_DIR    = 3'd1;
   localparam logic [2:0] REG_CFG_LO = 3'd2;
   localparam logic [2:0] REG_CFG_HI = 3'd3;
   localparam logic [2:0] REG_MASK   = 3'd4;
   localparam logic [2:0] REG_STATUS = 3'd5;
   localparam logic [2:0] REG_BOTH   = 3'd6;

   // Per-pin interrupt trigger modes.
   localparam logic [1:0] MODE_LOW  = 2'd0;
   localparam logic [1:0] MODE_HIGH = 2'd1;
   localparam logic [1:0] MODE_RISE = 2'd2;
   localparam logic [1:0] MODE_FALL = 2'd3;

   // Pins covered by one configuration word.
   localparam int HALF_PINS = 16;

   typedef struct packed {
      logic [1:0]  func;
      logic [2:0]  reg_index;
      logic [31:0] write_data;
      logic [31:0] pad_levels;
   } req_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic [31:0] pin_drive;
      logic [31:0] output_enable;
      logic        irq;
   } rsp_type;

endpackage

>>> design/gpio_edge_det.sv
// Per-pin interrupt condition check against the new and previous pad sample.
module gpio_edge_det #(
   parameter int PIN_COUNT = 32
) (
   input  logic [PIN_COUNT-1:0] pads,
   input  logic [PIN_COUNT-1:0] prev_pads,
   input  logic [PIN_COUNT-1:0] both_sel,
   input  logic [31:0]          cfg_lo,
   input  logic [31:0]          cfg_hi,
   output logic [PIN_COUNT-1:0] hits
);

   localparam int Half = gpio_pkg::HALF_PINS;

   for (genvar p = 0; p < PIN_COUNT; p++) begin : g_pin
      logic [1:0] mode;
      logic       hit;

      if (p < Half) begin : g_lo
         assign mode = cfg_lo[2*p +: 2];
      end else begin : g_hi
         assign mode = cfg_hi[2*(p-Half) +: 2];
      end

      always_comb begin
         if (both_sel[p]) begin
            hit = pads[p] ^ prev_pads[p];
         end else begin
            case (mode)
               gpio_pkg::MODE_LOW:  hit = !pads[p];
               gpio_pkg::MODE_HIGH: hit = pads[p];
               gpio_pkg::MODE_RISE: hit = pads[p] & !prev_pads[p];
               gpio_pkg::MODE_FALL: hit = !pads[p] & prev_pads[p];
               default:             hit = 1'b0;
            endcase
         end
      end

      assign hits[p] = hit;
   end

endmodule

>>> design/gpio_rsp_buf.sv
// Result register with one skid entry, so a new word can be taken while the
// previous result is still held by the receiver.
module gpio_rsp_buf (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  gpio_pkg::rsp_type push_data,
   output logic              full,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output gpio_pkg::rsp_type rsp_data
);

   logic              out_valid_ff, out_valid_in;
   logic              skid_valid_ff, skid_valid_in;
   gpio_pkg::rsp_type out_ff, out_in;
   gpio_pkg::rsp_type skid_ff, skid_in;
   logic              pop;

   assign pop = out_valid_ff && !rsp_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_in       = push_data;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = push_data;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign full      = skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

>>> design/gpio_port_with_pin_interrupts.sv
// A result word is registered in the result register, or in the skid entry while that is held, before it reaches rsp.
// Throughput: one request per cycle while req_stall is low; every access and tick is a single pass of bitwise logic.
// The result register has a one-word skid entry, so the port stalls only when both are full.
// Reset is synchronous and active high; it clears every port register, the previous pad
// sample and the result buffer, leaving all pins as inputs with interrupts masked.
`include "gpio_port_with_pin_interrupts_assert.svh"

module gpio_port_with_pin_interrupts #(
   parameter int PIN_COUNT = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  gpio_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output gpio_pkg::rsp_type rsp_data
);

   // Port registers. Only the pins that exist are stored; the two
   // configuration words are held in full, although fields of absent pins
   // have no effect on the interrupt logic.
   logic [PIN_COUNT-1:0] data_ff,   data_in;
   logic [PIN_COUNT-1:0] dir_ff,    dir_in;
   logic [PIN_COUNT-1:0] mask_ff,   mask_in;
   logic [PIN_COUNT-1:0] status_ff, status_in;
   logic [PIN_COUNT-1:0] both_ff,   both_in;
   logic [PIN_COUNT-1:0] prev_ff,   prev_in;
   logic [31:0]          cfg_lo_ff, cfg_lo_in;
   logic [31:0]          cfg_hi_ff, cfg_hi_in;

   logic                 accept;
   logic [PIN_COUNT-1:0] wdata_pins;
   logic [PIN_COUNT-1:0] pad_pins;
   logic [PIN_COUNT-1:0] hits;
   logic [31:0]          read_value;
   gpio_pkg::rsp_type    rsp_next;
   logic                 buf_full;

   assign accept     = req_valid && !req_stall;
   assign wdata_pins = req_data.write_data[PIN_COUNT-1:0];
   assign pad_pins   = req_data.pad_levels[PIN_COUNT-1:0];

   // Interrupt conditions for a tick, comparing the new pad levels with the
   // sample taken on the previous tick.
   gpio_edge_det #(
      .PIN_COUNT (PIN_COUNT)
   ) u_edge_det (
      .pads      (pad_pins),
      .prev_pads (prev_ff),
      .both_sel  (both_ff),
      .cfg_lo    (cfg_lo_ff),
      .cfg_hi    (cfg_hi_ff),
      .hits      (hits)
   );

   // Each accepted word either reads a register, writes one, or samples the
   // pads. Results reflect the state after the word has taken effect.
   always_comb begin
      data_in    = data_ff;
      dir_in     = dir_ff;
      mask_in    = mask_ff;
      status_in  = status_ff;
      both_in    = both_ff;
      prev_in    = prev_ff;
      cfg_lo_in  = cfg_lo_ff;
      cfg_hi_in  = cfg_hi_ff;
      read_value = '0;
      if (accept) begin
         case (req_data.func)
            gpio_pkg::FUNC_READ: begin
               unique case (req_data.reg_index)
                  // Input pins read back the last pad sample, output pins
                  // their driven value.
                  gpio_pkg::REG_DATA:
                     read_value = 32'((data_ff & dir_ff) | (prev_ff & ~dir_ff));
                  gpio_pkg::REG_DIR:    read_value = 32'(dir_ff);
                  gpio_pkg::REG_CFG_LO: read_value = cfg_lo_ff;
                  gpio_pkg::REG_CFG_HI: read_value = cfg_hi_ff;
                  gpio_pkg::REG_MASK:   read_value = 32'(mask_ff);
                  gpio_pkg::REG_STATUS: read_value = 32'(status_ff);
                  gpio_pkg::REG_BOTH:   read_value = 32'(both_ff);
                  default:              read_value = '0;
               endcase
            end
            gpio_pkg::FUNC_WRITE: begin
               unique case (req_data.reg_index)
                  gpio_pkg::REG_DATA:   data_in   = wdata_pins;
                  gpio_pkg::REG_DIR:    dir_in    = wdata_pins;
                  gpio_pkg::REG_CFG_LO: cfg_lo_in = req_data.write_data;
                  gpio_pkg::REG_CFG_HI: cfg_hi_in = req_data.write_data;
                  gpio_pkg::REG_MASK:   mask_in   = wdata_pins;
                  // Status is write-one-to-clear.
                  gpio_pkg::REG_STATUS: status_in = status_ff & ~wdata_pins;
                  gpio_pkg::REG_BOTH:   both_in   = wdata_pins;
                  default: ;
               endcase
            end
            gpio_pkg::FUNC_TICK: begin
               // Status bits are set whatever the mask; level modes set
               // them again on every tick while the level holds.
               status_in = status_ff | hits;
               prev_in   = pad_pins;
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      rsp_next.read_data     = read_value;
      rsp_next.pin_drive     = 32'(data_in);
      rsp_next.output_enable = 32'(dir_in);
      rsp_next.irq           = |(status_in & mask_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_ff   <= '0;
         dir_ff    <= '0;
         mask_ff   <= '0;
         status_ff <= '0;
         both_ff   <= '0;
         prev_ff   <= '0;
         cfg_lo_ff <= '0;
         cfg_hi_ff <= '0;
      end else begin
         data_ff   <= data_in;
         dir_ff    <= dir_in;
         mask_ff   <= mask_in;
         status_ff <= status_in;
         both_ff   <= both_in;
         prev_ff   <= prev_in;
         cfg_lo_ff <= cfg_lo_in;
         cfg_hi_ff <= cfg_hi_in;
      end
   end

   // Result register plus skid entry; the request side stalls only when the
   // skid entry is occupied.
   gpio_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (rsp_next),
      .full      (buf_full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   assign req_stall = buf_full;

   // A tick may only add status bits, never remove them.
   `GPIO_ASSERT_NEXT(a_tick_keeps_status, clock, reset,
      !reset && accept && req_data.func == gpio_pkg::FUNC_TICK,
      (status_ff & $past(status_ff)) == $past(status_ff),
      "pad tick cleared an interrupt status bit")

   // Writing ones to status clears those bits.
   `GPIO_ASSERT_NEXT(a_status_w1c, clock, reset,
      !reset && accept && req_data.func == gpio_pkg::FUNC_WRITE &&
      req_data.reg_index == gpio_pkg::REG_STATUS,
      (status_ff & $past(wdata_pins)) == '0,
      "status bits survived a write-one-to-clear")

   // The port stalls only while a result is waiting on the rsp side.
   `GPIO_ASSERT_NOW(a_stall_has_result, clock, reset,
      req_stall,
      rsp_valid,
      "request stalled with no result pending")

   // A register read leaves the port state untouched.
   `GPIO_ASSERT_NEXT(a_read_no_side_effect, clock, reset,
      !reset && accept && req_data.func == gpio_pkg::FUNC_READ,
      $stable(data_ff) && $stable(dir_ff) && $stable(status_ff) && $stable(prev_ff),
      "register read changed port state")

endmodule

>>> tb/tb_gpio_port_with_pin_interrupts.sv
`timescale 1ns / 1ps

module tb_gpio_port_with_pin_interrupts;

   // Port width under test. Pins at and above this count do not exist.
   localparam int          PINS     = 32;
   localparam logic [31:0] PIN_MASK = 32'hFFFF_FFFF >> (32 - PINS);

   // Codes that the package leaves unnamed: the spare func value and the spare register slot.
   localparam logic [1:0] FUNC_NONE = 2'd3;
   localparam logic [2:0] REG_NONE  = 3'd7;

   // A directed row either carries a result typed in by hand or takes it from the port model.
   localparam logic TYPED      = 1'b1;
   localparam logic FROM_MODEL = 1'b0;

   localparam int RANDOM_WORDS = 700;
   localparam int FLOOD_WORDS  = 25;
   localparam int FLOOD_HOLD   = 80;
   localparam int CYCLE_LIMIT  = 200000;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   gpio_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   gpio_pkg::rsp_type rsp_data;

   always #1 clock = ~clock;

   gpio_port_with_pin_interrupts #(
      .PIN_COUNT(PINS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   // ---------------------------------------------------------------------------------------
   // Port model. These mirror the registers of the block and move on once per accepted word.
   // ---------------------------------------------------------------------------------------
   logic [31:0] m_data   = '0;
   logic [31:0] m_dir    = '0;
   logic [31:0] m_cfg_lo = '0;
   logic [31:0] m_cfg_hi = '0;
   logic [31:0] m_mask   = '0;
   logic [31:0] m_status = '0;
   logic [31:0] m_both   = '0;
   logic [31:0] m_prev   = '0;

   // Results still owed by the port, oldest first.
   gpio_pkg::rsp_type rsp_due[$];

   int mismatches  = 0;
   int cycle_count = 0;

   // Set by the sender when it wants the receiver to hold off for a long stretch.
   bit flood_req = 1'b0;

   // Applies one request word to the model and returns the result word it should produce.
   // The outputs always show the state after the access or tick has taken effect.
   function automatic gpio_pkg::rsp_type step_port(input gpio_pkg::req_type w);
      logic [31:0]       pads;
      logic [31:0]       rise;
      logic [31:0]       fall;
      logic [31:0]       hits;
      logic [1:0]        mode;
      logic              hit;
      gpio_pkg::rsp_type r;
      pads = w.pad_levels & PIN_MASK;
      r    = '0;
      case (w.func)
         gpio_pkg::FUNC_READ: begin
            case (w.reg_index)
               // Input pins read back the last pad sample, output pins the data register.
               gpio_pkg::REG_DATA:
                  r.read_data = ((m_data & m_dir) | (m_prev & ~m_dir)) & PIN_MASK;
               gpio_pkg::REG_DIR:    r.read_data = m_dir;
               gpio_pkg::REG_CFG_LO: r.read_data = m_cfg_lo;
               gpio_pkg::REG_CFG_HI: r.read_data = m_cfg_hi;
               gpio_pkg::REG_MASK:   r.read_data = m_mask;
               gpio_pkg::REG_STATUS: r.read_data = m_status;
               gpio_pkg::REG_BOTH:   r.read_data = m_both;
               default:              r.read_data = '0;
            endcase
         end
         gpio_pkg::FUNC_WRITE: begin
            case (w.reg_index)
               gpio_pkg::REG_DATA:   m_data   = w.write_data & PIN_MASK;
               gpio_pkg::REG_DIR:    m_dir    = w.write_data & PIN_MASK;
               // The configuration words keep every bit, even the fields of absent pins.
               gpio_pkg::REG_CFG_LO: m_cfg_lo = w.write_data;
               gpio_pkg::REG_CFG_HI: m_cfg_hi = w.write_data;
               gpio_pkg::REG_MASK:   m_mask   = w.write_data & PIN_MASK;
               gpio_pkg::REG_STATUS: m_status = m_status & ~w.write_data;
               gpio_pkg::REG_BOTH:   m_both   = w.write_data & PIN_MASK;
               default:              ;
            endcase
         end
         gpio_pkg::FUNC_TICK: begin
            rise = pads & ~m_prev;
            fall = ~pads & m_prev;
            hits = '0;
            for (int p = 0; p < PINS; p++) begin
               mode = (p < gpio_pkg::HALF_PINS) ? m_cfg_lo[2*p +: 2]
                                                : m_cfg_hi[2*(p-gpio_pkg::HALF_PINS) +: 2];
               if (m_both[p]) begin
                  // The both-edges select overrides whatever the pin's field says.
                  hit = rise[p] | fall[p];
               end else begin
                  case (mode)
                     gpio_pkg::MODE_LOW:  hit = ~pads[p];
                     gpio_pkg::MODE_HIGH: hit = pads[p];
                     gpio_pkg::MODE_RISE: hit = rise[p];
                     default:             hit = fall[p];
                  endcase
               end
               hits[p] = hit;
            end
            // Status bits are set whatever the mask says; the mask only gates irq.
            m_status = (m_status | hits) & PIN_MASK;
            m_prev   = pads;
         end
         default: ;
      endcase
      r.pin_drive     = m_data;
      r.output_enable = m_dir;
      r.irq           = |(m_status & m_mask);
      return r;
   endfunction

   // ---------------------------------------------------------------------------------------
   // Directed stimulus table.
   // ---------------------------------------------------------------------------------------
   typedef struct packed {
      gpio_pkg::req_type word;
      logic              typed;
      gpio_pkg::rsp_type want;
   } stim_row_type;

   stim_row_type stim_table[$];

   function automatic gpio_pkg::rsp_type fields(input logic [31:0] rd,
                                                input logic [31:0] drv,
                                                input logic [31:0] oe, input logic irq);
      gpio_pkg::rsp_type r;
      r.read_data     = rd;
      r.pin_drive     = drv;
      r.output_enable = oe;
      r.irq           = irq;
      return r;
   endfunction

   function automatic void row(input logic [1:0] f, input logic [2:0] idx,
                               input logic [31:0] wd, input logic [31:0] pads,
                               input logic typed, input gpio_pkg::rsp_type want);
      stim_row_type s;
      s.word.func       = f;
      s.word.reg_index  = idx;
      s.word.write_data = wd;
      s.word.pad_levels = pads;
      s.typed           = typed;
      s.want            = want;
      stim_table.push_back(s);
   endfunction

   // ---------------------------------------------------------------------------------------
   // Sender. A word is held on the bus until the port takes it. At the edge where it is
   // taken the model is stepped, so expectations queue up in acceptance order.
   // ---------------------------------------------------------------------------------------
   task automatic offer(input gpio_pkg::req_type w, input logic typed,
                        input gpio_pkg::rsp_type want);
      gpio_pkg::rsp_type r;
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (req_stall);
      r = step_port(w);
      rsp_due.push_back(typed ? want : r);
   endtask

   // Drops valid for a number of cycles. A gap of zero leaves valid high for the next word.
   task automatic pause(input int cycles);
      if (cycles > 0) begin
         req_valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   initial begin
      int                burst;
      int                sel;
      logic [31:0]       last_pads;
      logic [31:0]       wd;
      logic [31:0]       pads;
      gpio_pkg::req_type w;

      burst     = 0;
      last_pads = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Reset state: everything reads as zero, all pins are inputs and irq is low.
      row(gpio_pkg::FUNC_READ,  gpio_pkg::REG_DATA,   '0, '0, TYPED,
          fields('0, '0, '0, 1'b0));
      row(gpio_pkg::FUNC_READ,  gpio_pkg::REG_STATUS, '0, '0, TYPED,
          fields('0, '0, '0, 1'b0));
      // Every pin an output driving high; the data read then returns the data register.
      row(gpio_pkg::FUNC_WRITE, gpio_pkg::REG_DIR,    '1, '0, TYPED,
          fields('0, '0, PIN_MASK, 1'b0));
      row(gpio_pkg::FUNC_WRITE, gpio_pkg::REG_DATA,   '1, '0, TYPED,
          fields('0, PIN_MASK, PIN_MASK, 1'b0));
      row(gpio_pkg::FUNC_READ,  gpio_pkg::REG_DATA,   '0, '1, TYPED,
          fields(PIN_MASK, PIN_MASK, PIN_MASK, 1'b0));
      row(gpio_pkg::FUNC_WRITE, gpio_pkg::REG_DIR,    '0, '0, TYPED,
          fields('0, PIN_MASK, '0, 1'b0));
      row(gpio_pkg::FUNC_WRITE, gpio_pkg::REG_MASK,   '1, '0, TYPED,
          fields('0, PIN_MASK, '0, 1'b0));
      // Fields reset to low-level mode, so a tick with all pads low hits every pin.
      row(gpio_pkg::FUNC_TICK,  gpio_pkg::REG_DATA,   '0, '0, FROM_MODEL, '0);
      row(gpio_pkg::FUNC_WRITE, gpio_pkg::REG_STATUS, '1, '0, FROM_MODEL, '0);
      // Low half high-level, high half rising edge; two ticks at all-ones show that the
      // level pins fire again while the edge pins fire only once.
      row(gpio_pkg::FUNC_WRITE, gpio_pkg::REG_CFG_LO, {16{gpio_pkg::MODE_HIGH}}, '0,
          FROM_MODEL, '0);
      row(gpio_pkg::FUNC_WRITE, gpio_pkg::REG_CFG_HI, {16{gpio_pkg::MODE_RISE}}, '0,
          FROM_MODEL, '0);
      row(gpio_pkg::FUNC_TICK,  gpio_pkg::REG_DATA,   '0, '1, FROM_MODEL, '0);
      row(gpio_pkg::FUNC_WRITE, gpio_pkg::REG_STATUS, '1, '0, FROM_MODEL, '0);
      row(gpio_pkg::FUNC_TICK,  gpio_pkg::REG_DATA,   '0, '1, FROM_MODEL, '0);
      row(gpio_pkg::FUNC_READ,  gpio_pkg::REG_STATUS, '0, '0, FROM_MODEL, '0);
      // Falling edge on the low half, low level on the high half.
      row(gpio_pkg::FUNC_WRITE, gpio_pkg::REG_CFG_LO, {16{gpio_pkg::MODE_FALL}}, '0,
          FROM_MODEL, '0);
      row(gpio_pkg::FUNC_WRITE, gpio_pkg::REG_CFG_HI, {16{gpio_pkg::MODE_LOW}},  '0,
          FROM_MODEL, '0);
      row(gpio_pkg::FUNC_TICK,  gpio_pkg::REG_DATA,   '0, '0, FROM_MODEL, '0);
      // Both-edges select overrides the fields; pads then toggle in a chequered pattern.
      row(gpio_pkg::FUNC_WRITE, gpio_pkg::REG_BOTH,   '1, '0, FROM_MODEL, '0);
      row(gpio_pkg::FUNC_TICK,  gpio_pkg::REG_DATA,   '0, 32'hA5A5_5A5A, FROM_MODEL, '0);
      row(gpio_pkg::FUNC_READ,  gpio_pkg::REG_DATA,   '0, '0, FROM_MODEL, '0);
      // The spare register slot and the spare func value do nothing.
      row(gpio_pkg::FUNC_WRITE, REG_NONE,             '1, '1, FROM_MODEL, '0);
      row(gpio_pkg::FUNC_READ,  REG_NONE,             '1, '1, FROM_MODEL, '0);
      row(FUNC_NONE,            gpio_pkg::REG_STATUS, '1, '1, FROM_MODEL, '0);
      row(gpio_pkg::FUNC_READ,  gpio_pkg::REG_CFG_LO, '0, '0, FROM_MODEL, '0);
      row(gpio_pkg::FUNC_READ,  gpio_pkg::REG_CFG_HI, '0, '0, FROM_MODEL, '0);
      row(gpio_pkg::FUNC_READ,  gpio_pkg::REG_BOTH,   '0, '0, FROM_MODEL, '0);
      row(gpio_pkg::FUNC_READ,  gpio_pkg::REG_MASK,   '0, '0, FROM_MODEL, '0);

      foreach (stim_table[k]) begin
         offer(stim_table[k].word, stim_table[k].typed, stim_table[k].want);
         pause($urandom_range(0, 2));
      end
      last_pads = m_prev;

      // Random part. Bursts of back-to-back words are broken by gaps of random length.
      // A third of the way in, one long burst runs while the receiver holds off, so that the
      // port fills up and has to stall its input.
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n == RANDOM_WORDS / 3) begin
            flood_req = 1'b1;
            burst     = FLOOD_WORDS;
         end else if (burst == 0) begin
            pause(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
            burst = $urandom_range(1, 30);
         end
         burst--;

         case ($urandom_range(0, 3))
            0:       wd = $urandom();
            1:       wd = '1;
            2:       wd = '0;
            default: wd = $urandom() & $urandom();
         endcase
         // Pads mostly move a little from the last sample so that edges stay sparse.
         case ($urandom_range(0, 4))
            0:       pads = $urandom();
            1:       pads = last_pads ^ (32'h1 << $urandom_range(0, 31));
            2:       pads = ~last_pads;
            3:       pads = last_pads ^ ($urandom() & $urandom());
            default: pads = ($urandom_range(0, 1) == 0) ? '0 : '1;
         endcase

         w.write_data = wd;
         w.pad_levels = pads;
         w.reg_index  = ($urandom_range(0, 15) == 0) ? REG_NONE : 3'($urandom_range(0, 6));
         sel = $urandom_range(0, 99);
         if (sel < 35) begin
            w.func    = gpio_pkg::FUNC_TICK;
            last_pads = pads & PIN_MASK;
         end else if (sel < 65) begin
            w.func = gpio_pkg::FUNC_WRITE;
            // Clears of the status register keep it from simply filling with ones.
            if ($urandom_range(0, 3) == 0)
               w.reg_index = gpio_pkg::REG_STATUS;
         end else if (sel < 95) begin
            w.func = gpio_pkg::FUNC_READ;
         end else begin
            w.func = FUNC_NONE;
         end
         offer(w, FROM_MODEL, '0);
      end
      req_valid <= 1'b0;

      // Wait for the port to deliver everything, then a few cycles more so that a stray
      // extra word would still be caught by the checker.
      while (rsp_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (mismatches == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   // ---------------------------------------------------------------------------------------
   // Receiver. It stalls on runs of its own choosing: free running, coin flips, a fixed
   // pattern and mostly stalled. Once, on the sender's request, it holds off for a long time.
   // ---------------------------------------------------------------------------------------
   initial begin
      int hold_left;
      int run_left;
      int mode;
      int phase;
      hold_left = 0;
      run_left  = 0;
      mode      = 0;
      phase     = 0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (flood_req) begin
            flood_req = 1'b0;
            hold_left = FLOOD_HOLD - 1;
            rsp_stall <= 1'b1;
         end else begin
            if (run_left == 0) begin
               mode     = $urandom_range(0, 3);
               run_left = $urandom_range(1, 40);
            end
            run_left--;
            phase++;
            case (mode)
               0:       rsp_stall <= 1'b0;
               1:       rsp_stall <= ($urandom_range(0, 1) == 0);
               2:       rsp_stall <= (phase % 3 == 0);
               default: rsp_stall <= ($urandom_range(0, 3) != 0);
            endcase
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Checker. Every word taken from the port is compared field by field with the oldest
   // expectation.
   // ---------------------------------------------------------------------------------------
   task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %h, got %h", $realtime, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      gpio_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (rsp_due.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result word, expected none, got %h",
                     $realtime, rsp_data);
         end else begin
            want = rsp_due.pop_front();
            check_field("read_data",     want.read_data,     rsp_data.read_data);
            check_field("pin_drive",     want.pin_drive,     rsp_data.pin_drive);
            check_field("output_enable", want.output_enable, rsp_data.output_enable);
            check_field("irq",           32'(want.irq),      32'(rsp_data.irq));
         end
      end
   end

   // A run that has not finished by this many cycles has hung somewhere.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

endmodule

>>> filelist.f
+incdir+design
design/gpio_pkg.sv
design/gpio_edge_det.sv
design/gpio_rsp_buf.sv
design/gpio_port_with_pin_interrupts.sv
tb/tb_gpio_port_with_pin_interrupts.sv
